// File: hdl/fal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_pkg
// Types and constants shared by the LRU frame allocator and its order cells.
// ----------------------------------------------------------------------------
package fal_pkg;

    localparam int FRAMES  = 16;
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int MODE_W  = 2;
    localparam int FRAME_W = 4;
    localparam int DATA_W  = 8;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_TOUCH = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Operation broadcast to every cell of the recency order.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_APPEND = 2'd1,   // write key into the first empty cell
        OP_MOVE   = 2'd2,   // take key out of the order and put it at the end
        OP_DROP   = 2'd3    // take key out of the order
    } t_op;

    typedef struct packed {
        t_op  op;
        t_idx key;
    } t_cell_cmd;

    // One order entry, handed from a cell to its left neighbor.
    typedef struct packed {
        logic valid;
        t_idx frame;
    } t_entry;

    // Status handed from a cell to its right neighbor.
    typedef struct packed {
        logic valid;    // this cell holds an entry
        logic seen;     // the key sits in this cell or one to its left
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage
`default_nettype wire

// File: hdl/fal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_cell
// One position of the recency order: holds a frame number and a valid bit,
// and shifts toward the head when an earlier entry leaves the order.
// ----------------------------------------------------------------------------
module fal_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fal_pkg::t_cell_cmd  i_cmd,
    input  fal_pkg::t_link      i_left,
    input  fal_pkg::t_entry     i_right,
    output fal_pkg::t_link      o_link,
    output fal_pkg::t_entry     o_entry
);

    logic          r_valid;
    fal_pkg::t_idx r_frame;
    logic          n_valid;
    fal_pkg::t_idx n_frame;
    logic          match;
    logic          shift;

    assign match = r_valid && (r_frame == i_cmd.key);
    assign shift = i_left.seen || match;

    assign o_link.valid  = r_valid;
    assign o_link.seen   = shift;
    assign o_entry.valid = r_valid;
    assign o_entry.frame = r_frame;

    always_comb begin
        n_valid = r_valid;
        n_frame = r_frame;
        case (i_cmd.op)
            fal_pkg::OP_APPEND: begin
                if (!r_valid && i_left.valid) begin
                    n_valid = 1'b1;
                    n_frame = i_cmd.key;
                end
            end
            fal_pkg::OP_MOVE: begin
                // The last valid cell behind the key receives the key itself.
                if (shift && r_valid) begin
                    if (i_right.valid) begin
                        n_frame = i_right.frame;
                    end else begin
                        n_frame = i_cmd.key;
                    end
                end
            end
            fal_pkg::OP_DROP: begin
                if (shift) begin
                    n_valid = i_right.valid;
                    n_frame = i_right.frame;
                end
            end
            default: begin
                n_valid = r_valid;
                n_frame = r_frame;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_frame <= n_frame;
    end

endmodule
`default_nettype wire

// File: hdl/frame_allocator_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_allocator_lru
// Frame allocator with least-recently-used replacement. A row of cells holds
// the frames in use from least recent (cell 0) to most recent.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload
//  s_axis  | in  | tuser: mode[1:0]; tdata: frame[3:0], zero pad [7:4]
//  m_axis  | out | tdata: frame_out[3:0], evicted[4], status[5], pad [7:6]
//
//  Each request is captured in the idle state; in the execute state the used
//  bits are searched and the whole cell row updates at once.
//  Reset empties the order and frees every frame; the reset is synchronous.
//  A result waits in the output register; the next request is captured
//  meanwhile, and its update holds until the output register is free.
// ----------------------------------------------------------------------------
module frame_allocator_lru (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [3:0] frame, [7:4] zero
    input  wire  [1:0] s_axis_tuser,   // [1:0] mode
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [3:0] frame_out, [4] evicted, [5] status
);

    fal_pkg::t_state    r_state;
    fal_pkg::t_mode     r_mode;
    fal_pkg::t_frame    r_frame;
    logic [fal_pkg::FRAMES-1:0] r_used;
    logic [fal_pkg::FRAMES-1:0] n_used;
    logic               r_out_valid;
    logic [fal_pkg::DATA_W-1:0] r_out_data;
    logic [fal_pkg::DATA_W-1:0] n_out_data;

    fal_pkg::t_cell_cmd cmd;
    fal_pkg::t_link     links   [fal_pkg::FRAMES+1];
    fal_pkg::t_entry    entries [fal_pkg::FRAMES+1];

    logic               fire;
    logic               full;
    fal_pkg::t_idx      low_free;
    fal_pkg::t_idx      idx;
    logic               in_use;

    assign s_axis_tready = (r_state == fal_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign fire = (r_state == fal_pkg::ST_EXEC) && (!r_out_valid || m_axis_tready);
    assign full = &r_used;
    assign idx  = fal_pkg::t_idx'(r_frame);

    // A frame number beyond the table counts as not in use.
    assign in_use = (32'(r_frame) < 32'(fal_pkg::FRAMES)) && r_used[idx];

    always_comb begin
        low_free = '0;
        for (int i = fal_pkg::FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                low_free = fal_pkg::t_idx'(i);
            end
        end
    end

    always_comb begin
        cmd.op     = fal_pkg::OP_NONE;
        cmd.key    = idx;
        n_used     = r_used;
        n_out_data = '0;
        n_out_data[fal_pkg::FRAME_W-1:0] = r_frame;
        case (r_mode)
            fal_pkg::MODE_ALLOC: begin
                if (!full) begin
                    cmd.op           = fal_pkg::OP_APPEND;
                    cmd.key          = low_free;
                    n_used[low_free] = 1'b1;
                    n_out_data[fal_pkg::FRAME_W-1:0] = fal_pkg::t_frame'(low_free);
                end else begin
                    // Eviction rotates the head of the order to its tail.
                    cmd.op  = fal_pkg::OP_MOVE;
                    cmd.key = entries[0].frame;
                    n_out_data[fal_pkg::FRAME_W-1:0] = fal_pkg::t_frame'(entries[0].frame);
                    n_out_data[fal_pkg::FRAME_W]     = 1'b1;
                end
            end
            fal_pkg::MODE_TOUCH: begin
                if (in_use) begin
                    cmd.op = fal_pkg::OP_MOVE;
                end else begin
                    n_out_data[fal_pkg::FRAME_W+1] = 1'b1;
                end
            end
            fal_pkg::MODE_FREE: begin
                if (in_use) begin
                    cmd.op      = fal_pkg::OP_DROP;
                    n_used[idx] = 1'b0;
                end else begin
                    n_out_data[fal_pkg::FRAME_W+1] = 1'b1;
                end
            end
            default: begin
                cmd.op = fal_pkg::OP_NONE;
            end
        endcase
        if (!fire) begin
            cmd.op = fal_pkg::OP_NONE;
        end
    end

    assign links[0].valid = 1'b1;
    assign links[0].seen  = 1'b0;
    assign entries[fal_pkg::FRAMES].valid = 1'b0;
    assign entries[fal_pkg::FRAMES].frame = '0;

    for (genvar g = 0; g < fal_pkg::FRAMES; g++) begin : g_cell
        fal_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_left  (links[g]),
            .i_right (entries[g+1]),
            .o_link  (links[g+1]),
            .o_entry (entries[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fal_pkg::ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                fal_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= fal_pkg::ST_EXEC;
                    end
                end
                fal_pkg::ST_EXEC: begin
                    if (fire) begin
                        r_state <= fal_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= fal_pkg::ST_IDLE;
                end
            endcase
            if (fire) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode  <= fal_pkg::t_mode'(s_axis_tuser);
            r_frame <= s_axis_tdata[fal_pkg::FRAME_W-1:0];
        end
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU frame allocator. Requests go out from a
// queue, each accepted transfer is run through a behavioral allocator that
// keeps its own used bits and recency chain, and every returned transfer is
// checked field by field against the oldest prediction. Both channels idle
// at random, and the result channel stalls for one long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_REQS = 1450;
    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_STALL  = 150;
    localparam int SETTLE      = 10;

    typedef struct {
        fal_pkg::t_mode  mode;
        fal_pkg::t_frame frame;
        int              gap;
        bit              drain_first;  // wait until every result is back before offering
    } t_frame_req;

    typedef struct {
        fal_pkg::t_frame frame_out;
        logic            evicted;
        logic            status;
    } t_alloc_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;    // [3:0] frame, [7:4] zero
    logic [1:0] s_axis_tuser  = '0;    // [1:0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [3:0] frame_out, [4] evicted, [5] status

    t_frame_req    request_fifo[$];
    t_alloc_result pending_results[$];
    t_frame_req    cur_req;

    // Behavioral allocator state.
    bit            frame_busy [fal_pkg::FRAMES];
    fal_pkg::t_idx lru_chain[$];

    // Used frames as the request generator sees them.
    bit   gen_busy [fal_pkg::FRAMES];
    bit   gen_gaps_on = 1'b1;

    int   src_gap       = 0;
    int   sink_hold     = 0;
    int   sink_count    = 0;
    bit   long_stall_done = 1'b0;
    int   idle_cycles   = 0;
    int   errors        = 0;

    frame_allocator_lru i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic t_alloc_result predict_allocation(fal_pkg::t_mode mode,
                                                         fal_pkg::t_frame frame);
        t_alloc_result r;
        int            slot;
        fal_pkg::t_idx victim;
        r.frame_out = frame;
        r.evicted   = 1'b0;
        r.status    = 1'b0;
        slot        = -1;
        case (mode)
            fal_pkg::MODE_ALLOC: begin
                for (int f = 0; f < fal_pkg::FRAMES; f++)
                    if (!frame_busy[f] && slot < 0) slot = f;
                if (slot >= 0) begin
                    frame_busy[slot] = 1'b1;
                    lru_chain.push_back(fal_pkg::t_idx'(slot));
                    r.frame_out = fal_pkg::t_frame'(slot);
                end else begin
                    // Every frame is in use: the least recent one is recycled.
                    victim = lru_chain.pop_front();
                    lru_chain.push_back(victim);
                    r.frame_out = fal_pkg::t_frame'(victim);
                    r.evicted   = 1'b1;
                end
            end
            fal_pkg::MODE_TOUCH, fal_pkg::MODE_FREE: begin
                if (int'(frame) >= fal_pkg::FRAMES || !frame_busy[frame]) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = 0; i < lru_chain.size(); i++)
                        if (lru_chain[i] == fal_pkg::t_idx'(frame)) slot = i;
                    if (slot >= 0) lru_chain.delete(slot);
                    if (mode == fal_pkg::MODE_TOUCH)
                        lru_chain.push_back(fal_pkg::t_idx'(frame));
                    else
                        frame_busy[frame] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_req(fal_pkg::t_mode mode, fal_pkg::t_frame frame, bit drain_first);
        t_frame_req req;
        int         slot;
        req.mode        = mode;
        req.frame       = frame;
        req.gap         = gen_gaps_on ? pick_gap() : 0;
        req.drain_first = drain_first;
        request_fifo.push_back(req);
        slot = -1;
        if (mode == fal_pkg::MODE_ALLOC) begin
            for (int f = 0; f < fal_pkg::FRAMES; f++)
                if (!gen_busy[f] && slot < 0) slot = f;
            if (slot >= 0) gen_busy[slot] = 1'b1;
        end else if (mode == fal_pkg::MODE_FREE && int'(frame) < fal_pkg::FRAMES) begin
            gen_busy[frame] = 1'b0;
        end
    endtask

    // Usually a frame that is in use, so touch and free do real work.
    function automatic fal_pkg::t_frame pick_frame();
        int used_list[$];
        for (int f = 0; f < fal_pkg::FRAMES; f++)
            if (gen_busy[f]) used_list.push_back(f);
        if (used_list.size() == 0 || $urandom_range(0, 99) < 20)
            return fal_pkg::t_frame'($urandom_range(0, 15));
        return fal_pkg::t_frame'(used_list[$urandom_range(0, used_list.size() - 1)]);
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(predict_allocation(cur_req.mode, cur_req.frame));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_fifo.size() != 0 && request_fifo[0].gap != 0) begin
                    src_gap = request_fifo[0].gap - 1;
                    request_fifo[0].gap = 0;
                    s_axis_tvalid <= 1'b0;
                end else if (request_fifo.size() != 0 &&
                             !(request_fifo[0].drain_first && pending_results.size() != 0)) begin
                    cur_req = request_fifo.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, cur_req.frame};
                    s_axis_tuser  <= cur_req.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sink_count++;
            if (sink_hold != 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (!long_stall_done && sink_count >= 300) begin
                long_stall_done = 1'b1;
                sink_hold       = LONG_STALL;
                m_axis_tready <= 1'b0;
            end else if ((sink_count / 160) % 4 == 3 || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                sink_hold = pick_gap();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer, actual tdata %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[3:0] !== want.frame_out) begin
                    $display("%0t: frame_out expected %0d actual %0d",
                             $time, want.frame_out, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[4] !== want.evicted) begin
                    $display("%0t: evicted expected %0b actual %0b",
                             $time, want.evicted, m_axis_tdata[4]);
                    errors++;
                end
                if (m_axis_tdata[5] !== want.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, m_axis_tdata[5]);
                    errors++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int             n;
        int             epoch_len;
        int             r;
        bit             fill_epoch;
        fal_pkg::t_mode mode;

        // Empty allocator: touch and free of free frames, an unused mode.
        add_req(fal_pkg::MODE_TOUCH, 4'd0, 1'b0);
        add_req(fal_pkg::MODE_FREE, 4'd15, 1'b0);
        add_req(fal_pkg::MODE_NOP, 4'd15, 1'b0);
        add_req(fal_pkg::MODE_NOP, 4'd0, 1'b0);
        // Fill every frame, then allocate into a full table.
        for (int i = 0; i < fal_pkg::FRAMES; i++)
            add_req(fal_pkg::MODE_ALLOC, fal_pkg::t_frame'(i), 1'b0);
        add_req(fal_pkg::MODE_ALLOC, 4'd9, 1'b0);
        add_req(fal_pkg::MODE_TOUCH, 4'd1, 1'b0);
        add_req(fal_pkg::MODE_ALLOC, 4'd0, 1'b0);
        add_req(fal_pkg::MODE_FREE, 4'd15, 1'b0);
        add_req(fal_pkg::MODE_TOUCH, 4'd15, 1'b0);
        add_req(fal_pkg::MODE_ALLOC, 4'd0, 1'b0);
        add_req(fal_pkg::MODE_FREE, 4'd5, 1'b0);

        n = 0;
        while (n < RANDOM_REQS) begin
            epoch_len   = $urandom_range(30, 120);
            fill_epoch  = ($urandom_range(0, 1) != 0);
            gen_gaps_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < epoch_len && n < RANDOM_REQS; k++) begin
                r = $urandom_range(0, 99);
                if (fill_epoch)
                    mode = (r < 45) ? fal_pkg::MODE_ALLOC : (r < 75) ? fal_pkg::MODE_TOUCH :
                           (r < 93) ? fal_pkg::MODE_FREE : fal_pkg::MODE_NOP;
                else
                    mode = (r < 20) ? fal_pkg::MODE_ALLOC : (r < 45) ? fal_pkg::MODE_TOUCH :
                           (r < 93) ? fal_pkg::MODE_FREE : fal_pkg::MODE_NOP;
                add_req(mode, (mode == fal_pkg::MODE_TOUCH || mode == fal_pkg::MODE_FREE) ?
                        pick_frame() : fal_pkg::t_frame'($urandom_range(0, 15)),
                        n == 0 || n == RANDOM_REQS / 2);
                n++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_fifo.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
